>>> hw/rtl/hstc_pkg.sv
// Shared types and constants for the host traffic counter table.
// Used by hstc_search, hstc_counters and host_traffic_counter_table.
package hstc_pkg;

  localparam int HOST_ENTRIES = 64;
  localparam int IDX_W = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
  localparam int CNT_W = $clog2(HOST_ENTRIES + 1);
  localparam int OUT_IDX_W = 6;
  localparam int OUT_CNT_W = 7;

  typedef struct packed {
    logic [2:0]  addr_type;
    logic [4:0]  addr_len;
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
    logic [15:0] port;
  } key_t;

  typedef struct packed {
    logic [31:0] tx_frm;
    logic [31:0] tx_byt;
    logic [31:0] rx_frm;
    logic [31:0] rx_byt;
  } cnt_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } srch_stat_t;

  typedef struct packed {
    logic             start;
    logic [IDX_W-1:0] idx;
    logic             is_new;
    logic             sender;
    logic [15:0]      frame_count;
    logic [15:0]      byte_count;
    logic [1:0]       link_kind;
    logic [3:0]       port_kind;
  } cnt_req_t;

  typedef struct packed {
    logic done;
    cnt_t cnt;
  } cnt_res_t;

endpackage

>>> hw/rtl/host_traffic_counter_table.sv
// Per-host traffic counter table: top level with sequencer and output register.
// Update: the key comparator visits one stored entry per cycle, then a found or new
// entry's counters are read, added to and written back. Clear: empties the table
// without a search. One item is in work at a time; the next transfer is taken in the
// cycle after a result is loaded, also while that result waits.
// Reset (rst, synchronous) empties the table at once.
module host_traffic_counter_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [2:0]  addr_type,
  input  logic [4:0]  addr_len,
  input  logic [63:0] addr_hi,
  input  logic [63:0] addr_lo,
  input  logic [15:0] port,
  input  logic [1:0]  link_kind,
  input  logic [3:0]  port_kind,
  input  logic        sender,
  input  logic [15:0] frame_count,
  input  logic [15:0] byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  entry_index,
  output logic        is_new,
  output logic        table_full,
  output logic [31:0] tx_frame_total,
  output logic [31:0] tx_byte_total,
  output logic [31:0] rx_frame_total,
  output logic [31:0] rx_byte_total,
  output logic [6:0]  host_count
);
  import hstc_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_COUNT  = 2'd2;
  localparam logic [1:0] S_OUT    = 2'd3;

  logic [1:0]       state;
  logic [CNT_W-1:0] valid_entries;
  key_t             it_key;
  logic             it_sender;
  logic [15:0]      it_frm;
  logic [15:0]      it_byt;
  logic [1:0]       it_lkind;
  logic [3:0]       it_pkind;
  logic [IDX_W-1:0] res_idx;
  logic             res_new;
  logic             res_full;
  logic             res_clear;
  logic             accept;
  logic             full;
  logic             srch_start;
  logic             key_wr;
  srch_stat_t       srch;
  cnt_req_t         cnt_req;
  cnt_res_t         cnt_res;

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign full       = (valid_entries == CNT_W'(HOST_ENTRIES));
  assign srch_start = accept && !mode;
  assign key_wr     = (state == S_SEARCH) && srch.done && !srch.found && !full;

  always_comb begin
    cnt_req.start       = (state == S_SEARCH) && srch.done && (srch.found || !full);
    cnt_req.idx         = srch.found ? srch.idx : valid_entries[IDX_W-1:0];
    cnt_req.is_new      = !srch.found;
    cnt_req.sender      = it_sender;
    cnt_req.frame_count = it_frm;
    cnt_req.byte_count  = it_byt;
    cnt_req.link_kind   = it_lkind;
    cnt_req.port_kind   = it_pkind;
  end

  hstc_search u_search (
    .clk     (clk),
    .rst     (rst),
    .start   (srch_start),
    .key     (it_key),
    .count   (valid_entries),
    .wr_en   (key_wr),
    .wr_addr (valid_entries[IDX_W-1:0]),
    .stat    (srch)
  );

  hstc_counters u_counters (
    .clk (clk),
    .rst (rst),
    .req (cnt_req),
    .res (cnt_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      valid_entries <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            it_key    <= '{addr_type, addr_len, addr_hi, addr_lo, port};
            it_sender <= sender;
            it_frm    <= frame_count;
            it_byt    <= byte_count;
            it_lkind  <= link_kind;
            it_pkind  <= port_kind;
            res_clear <= mode;
            res_full  <= 1'b0;
            res_new   <= 1'b0;
            res_idx   <= '0;
            if (mode) begin
              valid_entries <= '0;
              state         <= S_OUT;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (srch.done) begin
            if (srch.found) begin
              res_idx <= srch.idx;
              state   <= S_COUNT;
            end else if (full) begin
              res_full <= 1'b1;
              state    <= S_OUT;
            end else begin
              res_idx       <= valid_entries[IDX_W-1:0];
              res_new       <= 1'b1;
              valid_entries <= valid_entries + CNT_W'(1);
              state         <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          if (cnt_res.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            entry_index <= OUT_IDX_W'(res_idx);
            is_new      <= res_new;
            table_full  <= res_full;
            host_count  <= OUT_CNT_W'(valid_entries);
            if (res_full || res_clear) begin
              tx_frame_total <= '0;
              tx_byte_total  <= '0;
              rx_frame_total <= '0;
              rx_byte_total  <= '0;
            end else begin
              tx_frame_total <= cnt_res.cnt.tx_frm;
              tx_byte_total  <= cnt_res.cnt.tx_byt;
              rx_frame_total <= cnt_res.cnt.rx_frm;
              rx_byte_total  <= cnt_res.cnt.rx_byt;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    valid_entries <= CNT_W'(HOST_ENTRIES))
    else $error("entry count above table size");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && mode |=> (valid_entries == '0))
    else $error("clear transfer did not empty the table");

  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) && srch.done && srch.found |-> (CNT_W'(srch.idx) < valid_entries))
    else $error("match reported outside the valid entries");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> (!is_new && (entry_index == '0) && (tx_frame_total == '0)))
    else $error("dropped update reported entry data");

endmodule

>>> hw/rtl/hstc_search.sv
// Key memory and the single key comparator that walks the stored entries in order.
// Depends on hstc_pkg.
module hstc_search (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  hstc_pkg::key_t           key,
  input  logic [hstc_pkg::CNT_W-1:0] count,
  input  logic                     wr_en,
  input  logic [hstc_pkg::IDX_W-1:0] wr_addr,
  output hstc_pkg::srch_stat_t     stat
);
  import hstc_pkg::*;

  key_t             mem [HOST_ENTRIES];
  key_t             rdata;
  logic             busy;
  logic             pend;
  logic [CNT_W-1:0] issue;
  logic [IDX_W-1:0] pend_idx;
  logic             match;
  logic             exhausted;
  logic             done;
  logic             rd_en;

  assign match     = pend && (rdata == key);
  assign exhausted = (issue >= count);
  assign done      = busy && (match || (!pend && exhausted));
  assign rd_en     = busy && !done && !exhausted;

  assign stat.done  = done;
  assign stat.found = match;
  assign stat.idx   = pend_idx;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= key;
    end
    if (rd_en) begin
      rdata <= mem[issue[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      pend  <= 1'b0;
      issue <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      pend  <= 1'b0;
      issue <= '0;
    end else if (busy) begin
      if (done) begin
        busy <= 1'b0;
        pend <= 1'b0;
      end else begin
        pend <= rd_en;
        if (rd_en) begin
          issue    <= issue + CNT_W'(1);
          pend_idx <= issue[IDX_W-1:0];
        end
      end
    end
  end

  a_issue_bounded: assert property (@(posedge clk) disable iff (rst)
    busy |-> (issue <= count))
    else $error("search issued past the valid entries");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    done && !start |=> !busy)
    else $error("search still busy after completion");

  a_no_wr_busy: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en)
    else $error("key write during search read");

endmodule

>>> hw/rtl/hstc_counters.sv
// Counter memory with a read-modify-write adder for the traffic counters.
// Depends on hstc_pkg.
module hstc_counters (
  input  logic                clk,
  input  logic                rst,
  input  hstc_pkg::cnt_req_t  req,
  output hstc_pkg::cnt_res_t  res
);
  import hstc_pkg::*;

  cnt_t             mem [HOST_ENTRIES];
  logic [5:0]       kind_mem [HOST_ENTRIES];
  cnt_t             rdata;
  cnt_t             base;
  cnt_t             sum;
  cnt_t             result;
  logic             add;
  logic             done;
  logic [IDX_W-1:0] idx;
  logic             is_new;
  logic             sender;
  logic [31:0]      frm;
  logic [31:0]      byt;

  assign base = is_new ? '0 : rdata;

  always_comb begin
    sum = base;
    if (sender) begin
      sum.tx_frm = base.tx_frm + frm;
      sum.tx_byt = base.tx_byt + byt;
    end else begin
      sum.rx_frm = base.rx_frm + frm;
      sum.rx_byt = base.rx_byt + byt;
    end
  end

  assign res.done = done;
  assign res.cnt  = result;

  always_ff @(posedge clk) begin
    if (req.start) begin
      rdata <= mem[req.idx];
      if (req.is_new) begin
        kind_mem[req.idx] <= {req.link_kind, req.port_kind};
      end
    end
    if (add) begin
      mem[idx] <= sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add  <= 1'b0;
      done <= 1'b0;
    end else begin
      add  <= req.start;
      done <= add;
      if (req.start) begin
        idx    <= req.idx;
        is_new <= req.is_new;
        sender <= req.sender;
        frm    <= 32'(req.frame_count);
        byt    <= 32'(req.byte_count);
      end
      if (add) begin
        result <= sum;
      end
    end
  end

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    req.start |=> add ##1 done)
    else $error("counter update did not complete in two cycles");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    add |-> !req.start)
    else $error("counter update started while another was in flight");

  a_new_from_zero: assert property (@(posedge clk) disable iff (rst)
    add && is_new |=> (sender ? (result.rx_frm == 32'd0) : (result.tx_frm == 32'd0)))
    else $error("new entry did not start from zeroed counters");

endmodule
